// File: design/sds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared dual stack package
// Types, codes and defaults for the shared dual stack core.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int MAX_DEPTH_DEF     = 256;
    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int SIZE_W            = 9;
    localparam int OP_W              = 2;
    localparam int STATUS_W          = 2;
    localparam int VALUE_W           = 32;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic needs_read;
    } stat_t;

endpackage

// File: design/sds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared dual stack RAM
// Generic single-port memory with registered read data.
// ----------------------------------------------------------------------------
module sds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/sds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared dual stack datapath
// Request registers, stack counts, element memory and result registers.
// ----------------------------------------------------------------------------
module sds_datapath #(
    parameter int MAX_DEPTH     = sds_pkg::MAX_DEPTH_DEF,
    parameter int ELEMENT_WIDTH = sds_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sds_pkg::cmd_t                  cmd,
    output sds_pkg::stat_t                 stat,
    input  logic [sds_pkg::OP_W-1:0]       operation,
    input  logic                           stack_select,
    input  logic [sds_pkg::VALUE_W-1:0]    push_value,
    input  logic                           stack_size_we,
    input  logic [sds_pkg::SIZE_W-1:0]     stack_size,
    output logic [sds_pkg::STATUS_W-1:0]   status,
    output logic signed [sds_pkg::VALUE_W-1:0] top_value
);

    localparam int ADDR_W = $clog2(MAX_DEPTH);
    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > sds_pkg::SIZE_W) ? CNT_W : sds_pkg::SIZE_W) + 1;

    logic [sds_pkg::OP_W-1:0]     op_reg;
    logic                         sel_reg;
    logic [sds_pkg::VALUE_W-1:0]  val_reg;
    logic [sds_pkg::SIZE_W-1:0]   size_reg;
    logic [CNT_W-1:0]             low_reg;
    logic [CNT_W-1:0]             low_next;
    logic [CNT_W-1:0]             high_reg;
    logic [CNT_W-1:0]             high_next;
    logic [sds_pkg::STATUS_W-1:0] status_reg;
    logic [sds_pkg::STATUS_W-1:0] status_next;
    logic [sds_pkg::VALUE_W-1:0]  top_reg;
    logic [sds_pkg::VALUE_W-1:0]  top_next;

    logic [CMP_W-1:0]             size_ext;
    logic [CMP_W-1:0]             max_ext;
    logic [CNT_W-1:0]             size_used;
    logic [CNT_W:0]               count_sum;
    logic                         full;
    logic                         empty;
    logic                         is_push;
    logic                         is_read;
    logic                         push_ok;
    logic                         read_ok;
    logic [CNT_W-1:0]             waddr_full;
    logic [CNT_W-1:0]             raddr_full;
    logic [CNT_W-1:0]             addr_full;
    logic                         ram_we;
    logic [ELEMENT_WIDTH-1:0]     wr_data;
    logic [ELEMENT_WIDTH-1:0]     rd_data;
    logic [sds_pkg::VALUE_W-1:0]  rd_ext;

    assign size_ext  = CMP_W'(size_reg);
    assign max_ext   = CMP_W'(MAX_DEPTH);
    assign size_used = (size_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(size_ext);

    assign count_sum = {1'b0, low_reg} + {1'b0, high_reg};
    assign full      = count_sum >= {1'b0, size_used};
    assign empty     = sel_reg ? (high_reg == '0) : (low_reg == '0);
    assign is_push   = op_reg == sds_pkg::OP_PUSH;
    assign is_read   = (op_reg == sds_pkg::OP_POP) || (op_reg == sds_pkg::OP_PEEK);
    assign push_ok   = is_push && !full;
    assign read_ok   = is_read && !empty;

    assign waddr_full = sel_reg ? (size_used - CNT_W'(1) - high_reg) : low_reg;
    assign raddr_full = sel_reg ? (size_used - high_reg) : (low_reg - CNT_W'(1));
    assign addr_full  = is_push ? waddr_full : raddr_full;
    assign ram_we     = cmd.exec && push_ok;

    assign stat.needs_read = read_ok;

    generate
        if (ELEMENT_WIDTH >= sds_pkg::VALUE_W)
        begin : g_wide
            assign wr_data = ELEMENT_WIDTH'(val_reg);
            assign rd_ext  = rd_data[sds_pkg::VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign wr_data = val_reg[ELEMENT_WIDTH-1:0];
            assign rd_ext  = {{(sds_pkg::VALUE_W - ELEMENT_WIDTH){rd_data[ELEMENT_WIDTH-1]}},
                              rd_data};
        end
    endgenerate

    sds_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (MAX_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_full[ADDR_W-1:0]),
        .wdata (wr_data),
        .rdata (rd_data)
    );

    always_comb
    begin
        low_next    = low_reg;
        high_next   = high_reg;
        status_next = status_reg;
        top_next    = top_reg;
        if (stack_size_we)
        begin
            low_next  = '0;
            high_next = '0;
        end
        else if (cmd.exec)
        begin
            if (push_ok)
            begin
                if (sel_reg)
                begin
                    high_next = high_reg + CNT_W'(1);
                end
                else
                begin
                    low_next = low_reg + CNT_W'(1);
                end
            end
            else if (read_ok && (op_reg == sds_pkg::OP_POP))
            begin
                if (sel_reg)
                begin
                    high_next = high_reg - CNT_W'(1);
                end
                else
                begin
                    low_next = low_reg - CNT_W'(1);
                end
            end
            if (!read_ok)
            begin
                top_next = '0;
                if (is_push && full)
                begin
                    status_next = sds_pkg::STATUS_FULL;
                end
                else if (is_read)
                begin
                    status_next = sds_pkg::STATUS_EMPTY;
                end
                else
                begin
                    status_next = sds_pkg::STATUS_DONE;
                end
            end
        end
        else if (cmd.capture)
        begin
            status_next = sds_pkg::STATUS_DONE;
            top_next    = rd_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= sds_pkg::SIZE_W'(MAX_DEPTH);
            low_reg  <= '0;
            high_reg <= '0;
        end
        else
        begin
            if (stack_size_we)
            begin
                size_reg <= stack_size;
            end
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            sel_reg <= stack_select;
            val_reg <= push_value;
        end
        status_reg <= status_next;
        top_reg    <= top_next;
    end

    assign status    = status_reg;
    assign top_value = top_reg;

`ifndef SYNTHESIS
    a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
        count_sum <= {1'b0, size_used})
        else $error("Stack counts exceed the array size in use.");

    a_empty_pop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && is_read && empty && !stack_size_we)
            |=> ($stable(low_reg) && $stable(high_reg)))
        else $error("A request on an empty stack changed a count.");
`endif

endmodule

// File: design/sds_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared dual stack controller
// Sequences each request through execute and, if needed, memory read.
// ----------------------------------------------------------------------------
module sds_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output sds_pkg::cmd_t  cmd,
    input  sds_pkg::stat_t stat
);

    sds_pkg::state_t state_reg;
    sds_pkg::state_t state_next;
    logic            done_reg;
    logic            done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sds_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        unique case (state_reg)
            sds_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = sds_pkg::S_EXEC;
                end
            end
            sds_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.needs_read)
                begin
                    state_next = sds_pkg::S_READ;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = sds_pkg::S_IDLE;
                end
            end
            sds_pkg::S_READ:
            begin
                cmd.capture = 1'b1;
                done_next   = 1'b1;
                state_next  = sds_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sds_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != sds_pkg::S_IDLE;
    assign done = done_reg;

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == sds_pkg::S_EXEC))
        else $error("An accepted request did not enter execute.");

    a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sds_pkg::S_READ) |-> ($past(state_reg) == sds_pkg::S_EXEC))
        else $error("Memory read cycle not preceded by execute.");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (($past(state_reg) == sds_pkg::S_EXEC && !$past(stat.needs_read))
                  || $past(state_reg) == sds_pkg::S_READ))
        else $error("Result strobe without a finished request.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held for more than one cycle.");
`endif

endmodule

// File: design/shared_dual_stack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared dual stack core
// Two stacks sharing one element memory, with push, pop and peek requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on status and top_value for exactly one cycle while done is high; the
// receiver cannot stall, so it must take the result in that cycle. A push, an
// unknown operation or a failed request holds busy through the execute state,
// and its result strobe is registered as the core returns to idle, so a new
// request may be issued while done is high. A successful pop or peek also
// passes through a read state for the registered read of the element memory.
// Writing stack_size empties both stacks and must only be done while
// no request is outstanding.
module shared_dual_stack_core #(
    parameter int MAX_DEPTH     = sds_pkg::MAX_DEPTH_DEF,
    parameter int ELEMENT_WIDTH = sds_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sds_pkg::OP_W-1:0]           operation,
    input  logic                               stack_select,
    input  logic signed [sds_pkg::VALUE_W-1:0] push_value,
    input  logic                               stack_size_we,
    input  logic [sds_pkg::SIZE_W-1:0]         stack_size,
    output logic                               done,
    output logic [sds_pkg::STATUS_W-1:0]       status,
    output logic signed [sds_pkg::VALUE_W-1:0] top_value
);

    sds_pkg::cmd_t  cmd;
    sds_pkg::stat_t stat;

    sds_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    sds_datapath #(
        .MAX_DEPTH     (MAX_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .stack_select  (stack_select),
        .push_value    (push_value),
        .stack_size_we (stack_size_we),
        .stack_size    (stack_size),
        .status        (status),
        .top_value     (top_value)
    );

endmodule
